>>> rtl/spwm_pkg.sv
// Shared types, constants and the half-sine table for the sine PWM core.
// No dependencies; imported by every module of the block.
package spwm_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned GAIN_W   = 17;
  localparam int unsigned CMP_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned TABLE_DEPTH_DEFAULT = 32;
  localparam int unsigned SAMPLE_BITS_DEFAULT = 10;

  // Stored table is always 32 entries; deeper index ranges wrap onto it.
  localparam int unsigned SINE_ENTRIES = 32;
  localparam int unsigned SINE_IDX_W   = 5;

  localparam logic [CMP_W-1:0] SINE_TABLE [SINE_ENTRIES] = '{
    8'd0,   8'd25,  8'd49,  8'd73,  8'd96,  8'd118, 8'd139, 8'd159,
    8'd177, 8'd193, 8'd208, 8'd220, 8'd231, 8'd239, 8'd245, 8'd249,
    8'd250, 8'd249, 8'd245, 8'd239, 8'd231, 8'd220, 8'd208, 8'd193,
    8'd177, 8'd159, 8'd139, 8'd118, 8'd96,  8'd73,  8'd49,  8'd25
  };

  localparam logic [SAMPLE_W-1:0] UPPER_RESET = 10'd480;
  localparam logic [SAMPLE_W-1:0] LOWER_RESET = 10'd460;
  localparam logic [GAIN_W-1:0]   FAST_RESET  = 17'd328;
  localparam logic [GAIN_W-1:0]   SLOW_RESET  = 17'd13;
  localparam logic [GAIN_W-1:0]   MIN_RESET   = 17'd6554;
  localparam logic [GAIN_W-1:0]   MAX_RESET   = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER = 3'd0,
    REG_LOWER = 3'd1,
    REG_FAST  = 3'd2,
    REG_SLOW  = 3'd3,
    REG_MIN   = 3'd4,
    REG_MAX   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] upper_threshold;
    logic [SAMPLE_W-1:0] lower_threshold;
    logic [GAIN_W-1:0]   fast_step;
    logic [GAIN_W-1:0]   slow_step;
    logic [GAIN_W-1:0]   min_gain;
    logic [GAIN_W-1:0]   max_gain;
  } gain_cfg_t;

  // Per-request controls into the gain loop
  typedef struct packed {
    logic                advance;
    logic                run;
    logic                fast_mode;
    logic [SAMPLE_W-1:0] sample;
  } gain_req_t;

endpackage

>>> rtl/spwm_phase.sv
// Phase index counter, half-cycle flag and half-sine table lookup.
// Depends on spwm_pkg.
module spwm_phase #(
  parameter int unsigned TABLE_DEPTH = spwm_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  output logic [spwm_pkg::CMP_W-1:0] entry,
  output logic                       half_next
);
  import spwm_pkg::*;

  localparam int unsigned PW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [PW-1:0] phase_index;
  logic          half_cycle;
  logic [PW:0]   inc;
  logic          wrap;
  logic [PW-1:0] phase_index_next;
  logic [PW+SINE_IDX_W-1:0] idx_ext;

  assign inc  = {1'b0, phase_index} + (PW+1)'(1);
  assign wrap = inc >= (PW+1)'(TABLE_DEPTH);
  assign phase_index_next = wrap ? '0 : inc[PW-1:0];
  assign half_next = half_cycle ^ wrap;

  // entry after the advance, index taken mod 32
  assign idx_ext = {{SINE_IDX_W{1'b0}}, phase_index_next};
  assign entry   = SINE_TABLE[idx_ext[SINE_IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index <= '0;
      half_cycle  <= 1'b0;
    end else if (advance) begin
      phase_index <= phase_index_next;
      half_cycle  <= half_next;
    end
  end

endmodule

>>> rtl/spwm_gain.sv
// Amplitude feedback: gain register with hysteresis step and min/max clamp, zeroed when run is low.
// Depends on spwm_pkg.
module spwm_gain (
  input  logic                        clk,
  input  logic                        rst,
  input  spwm_pkg::gain_cfg_t         cfg,
  input  spwm_pkg::gain_req_t         req,
  output logic [spwm_pkg::GAIN_W-1:0] gain
);
  import spwm_pkg::*;

  logic [GAIN_W-1:0] gain_next;
  logic [GAIN_W-1:0] step;
  logic [GAIN_W:0]   sum;
  logic [GAIN_W-1:0] stepped;

  assign step = req.fast_mode ? cfg.fast_step : cfg.slow_step;
  assign sum  = {1'b0, gain} + {1'b0, step};

  always_comb begin
    if (req.sample > cfg.upper_threshold) begin
      stepped = (gain > step) ? gain - step : '0;
    end else if (req.sample < cfg.lower_threshold) begin
      stepped = sum[GAIN_W] ? '1 : sum[GAIN_W-1:0];
    end else begin
      stepped = gain;
    end

    if (!req.run) begin
      gain_next = '0;
    end else if (stepped <= cfg.min_gain) begin
      gain_next = cfg.min_gain;
    end else if (stepped >= cfg.max_gain) begin
      gain_next = cfg.max_gain;
    end else begin
      gain_next = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= '0;
    end else if (req.advance) begin
      gain <= gain_next;
    end
  end

endmodule

>>> rtl/sine_pwm_with_amplitude_feedback_core.sv
// Top level of the sine PWM bridge driver with output-voltage gain feedback.
// Depends on spwm_pkg, spwm_phase and spwm_gain.
//
// Usage:
//   One request on the s_ channel per PWM tick carries run, the sampled
//   output voltage and the fast/slow step select. Each request produces
//   exactly one result on the m_ channel: the two leg compare values, the
//   two low-side drives and the relay enable.
//   The edge that takes a request also loads its result, so m_tdata and
//   m_tvalid show it right after that edge. Throughput is one request per
//   cycle while the receiver keeps m_tready high, set by the single result
//   register; the lookup, 8x17 multiply and gain step/clamp all sit between
//   the state registers and that register.
//   When the receiver stalls (m_tready low with m_tvalid high) the result is
//   held and s_tready drops; it rises again in the cycle the result is
//   taken, so a new request can enter on that same edge.
//   Settings are written through cfg_we/cfg_index/cfg_data while idle;
//   indexes beyond the register list are ignored.
//   Reset (rst, synchronous) clears the phase index, half-cycle flag and
//   gain, empties the result register and restores the default thresholds,
//   steps and clamps.
module sine_pwm_with_amplitude_feedback_core #(
  parameter int unsigned TABLE_DEPTH = spwm_pkg::TABLE_DEPTH_DEFAULT,
  parameter int unsigned SAMPLE_BITS = spwm_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,  // run, output_voltage[9:0], fast_mode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,  // compare_a[7:0], compare_b[7:0],
                                                  // low_side_a, low_side_b, relay_on
  input  logic                          cfg_we,
  input  logic [spwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spwm_pkg::GAIN_W-1:0]   cfg_data
);
  import spwm_pkg::*;

  gain_cfg_t         cfg;
  gain_req_t         req;
  logic              accept;
  logic              run;
  logic              fast_mode;
  logic [SAMPLE_W-1:0] output_voltage;
  logic [SAMPLE_W-1:0] sample;
  logic [CMP_W-1:0]  entry;
  logic              half_next;
  logic [GAIN_W-1:0] gain;
  logic [CMP_W+GAIN_W-1:0] product;
  logic [CMP_W-1:0]  scaled;
  logic [CMP_W-1:0]  compare_a;
  logic [CMP_W-1:0]  compare_b;
  logic              low_side_a;
  logic              low_side_b;

  assign run            = s_tdata[0];
  assign output_voltage = s_tdata[SAMPLE_W:1];
  assign fast_mode      = s_tdata[SAMPLE_W+1];

  always_comb begin
    for (int i = 0; i < SAMPLE_W; i++) begin
      sample[i] = (i < SAMPLE_BITS) ? output_voltage[i] : 1'b0;
    end
  end

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper_threshold <= UPPER_RESET;
      cfg.lower_threshold <= LOWER_RESET;
      cfg.fast_step       <= FAST_RESET;
      cfg.slow_step       <= SLOW_RESET;
      cfg.min_gain        <= MIN_RESET;
      cfg.max_gain        <= MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UPPER: cfg.upper_threshold <= cfg_data[SAMPLE_W-1:0];
        REG_LOWER: cfg.lower_threshold <= cfg_data[SAMPLE_W-1:0];
        REG_FAST:  cfg.fast_step       <= cfg_data;
        REG_SLOW:  cfg.slow_step       <= cfg_data;
        REG_MIN:   cfg.min_gain        <= cfg_data;
        REG_MAX:   cfg.max_gain        <= cfg_data;
        default:   ;
      endcase
    end
  end

  spwm_phase #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_phase (
    .clk      (clk),
    .rst      (rst),
    .advance  (accept),
    .entry    (entry),
    .half_next(half_next)
  );

  assign req.advance   = accept;
  assign req.run       = run;
  assign req.fast_mode = fast_mode;
  assign req.sample    = sample;

  spwm_gain u_gain (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .gain(gain)
  );

  // compare uses the gain from before this tick's update, Q16 truncated and saturated at 255
  assign product = (CMP_W+GAIN_W)'(entry) * (CMP_W+GAIN_W)'(gain);
  assign scaled  = (product[CMP_W+GAIN_W-1:16] > (CMP_W+GAIN_W-16)'(8'hFF))
                   ? 8'hFF : product[16 +: CMP_W];

  assign compare_a  = (run && !half_next) ? scaled : '0;
  assign compare_b  = (run &&  half_next) ? scaled : '0;
  assign low_side_a = run && !half_next;
  assign low_side_b = run &&  half_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {5'b0, run, low_side_b, low_side_a, compare_b, compare_a};
    end
  end

endmodule
